### rtl/ptlc_pkg.sv
package ptlc_pkg;

   localparam int MAX_LEN_DEF  = 4096;
   localparam int ALPHABET_DEF = 26;
   localparam int LETTER_W     = 5;
   localparam int RESULT_W     = 13;
   localparam int EPOCH_W      = 8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_LETTER,
      ST_NODE,
      ST_TEXT,
      ST_CHILD,
      ST_FCHILD,
      ST_FNODE,
      ST_FINISH
   } ptlc_state_type;

endpackage

### rtl/ptlc_ram.sv
module ptlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/palindromic_tree_longest_chain_unit.sv
// Channel  Direction  tdata                                   tuser           tlast
// req      in         [4:0] letter, [7:5] zero                starts_string   ends_string
// rsp      out        [12:0] longest_path, [13] overflowed    -               -
//
// A letter walks suffix links; each step reads the node memory and, when the
// mirrored position is in range, then the text memory.
// A letter that creates a node adds a second walk and further child and node memory reads.
// After reset, and on every 256th string start, a pass clears the child memory,
// one entry a cycle, over all (MAX_LEN + 2) * ALPHABET entries; no request is taken then.
// A new request is taken while a result still waits on rsp.
module palindromic_tree_longest_chain_unit #(
   parameter int MAX_LEN  = ptlc_pkg::MAX_LEN_DEF,
   parameter int ALPHABET = ptlc_pkg::ALPHABET_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // letter, zero fill
   input  logic        req_tuser,   // starts_string
   input  logic        req_tlast,   // ends_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // longest_path, overflowed, zero fill
);
   import ptlc_pkg::*;

   localparam int NODES       = MAX_LEN + 2;
   localparam int NODE_W      = $clog2(NODES);
   localparam int POS_W       = $clog2(MAX_LEN + 1);
   localparam int LEN_W       = POS_W + 1;
   localparam int NWORD_W     = 2 * NODE_W + LEN_W;
   localparam int CHILD_DEPTH = NODES * ALPHABET;
   localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
   localparam int CWORD_W     = NODE_W + EPOCH_W;
   localparam logic [CHILD_AW-1:0] SWEEP_LAST = CHILD_AW'(CHILD_DEPTH - 1);
   localparam logic [NODE_W-1:0]   ROOT_ODD   = NODE_W'(1);

   ptlc_state_type state_ff, state_in;

   logic [LETTER_W-1:0] c_ff, c_in;
   logic                end_ff, end_in;
   logic                pend_ff, pend_in;
   logic [EPOCH_W-1:0]  epoch_ff, epoch_in;
   logic [CHILD_AW-1:0] sweep_ff, sweep_in;
   logic [NODE_W-1:0]   count_ff, count_in;
   logic [NODE_W-1:0]   last_ff, last_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [NODE_W-1:0]   best_ff, best_in;
   logic                ovf_ff, ovf_in;
   logic [NODE_W-1:0]   v_ff, v_in;
   logic                walk_ff, walk_in;
   logic [LEN_W-1:0]    len_v_ff, len_v_in;
   logic [NODE_W-1:0]   link_v_ff, link_v_in;
   logic [NODE_W-1:0]   chain_v_ff, chain_v_in;
   logic [LEN_W-1:0]    len_u_ff, len_u_in;
   logic [NODE_W-1:0]   link_u_ff, link_u_in;
   logic [NODE_W-1:0]   chain_u_ff, chain_u_in;
   logic [CHILD_AW-1:0] cu_addr_ff, cu_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0] rsp_path_ff, rsp_path_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic                text_we;
   logic [POS_W-1:0]    text_waddr, text_raddr;
   logic [LETTER_W-1:0] text_rd;
   logic                node_we;
   logic [NODE_W-1:0]   node_raddr;
   logic [NWORD_W-1:0]  node_wd, node_rd;
   logic                child_we;
   logic [CHILD_AW-1:0] child_waddr, child_raddr;
   logic [CWORD_W-1:0]  child_wd, child_rd;

   logic [LEN_W-1:0]    nd_len, cur_len;
   logic [NODE_W-1:0]   nd_link, nd_chain, cur_link, cur_chain;
   logic [LEN_W:0]      idx;
   logic                idx_ok;
   logic [CHILD_AW-1:0] child_addr;
   logic                child_hit;
   logic [NODE_W-1:0]   child_val, np, chain_f, chain_new;

   ptlc_ram #(.WIDTH(LETTER_W), .DEPTH(MAX_LEN + 1)) u_text (
      .clock(clock), .wr_en(text_we), .wr_addr(text_waddr), .wr_data(c_ff),
      .rd_addr(text_raddr), .rd_data(text_rd)
   );

   ptlc_ram #(.WIDTH(NWORD_W), .DEPTH(NODES)) u_node (
      .clock(clock), .wr_en(node_we), .wr_addr(count_ff + NODE_W'(1)), .wr_data(node_wd),
      .rd_addr(node_raddr), .rd_data(node_rd)
   );

   ptlc_ram #(.WIDTH(CWORD_W), .DEPTH(CHILD_DEPTH)) u_child (
      .clock(clock), .wr_en(child_we), .wr_addr(child_waddr), .wr_data(child_wd),
      .rd_addr(child_raddr), .rd_data(child_rd)
   );

   always_comb begin
      if (v_ff == '0) begin
         nd_link  = ROOT_ODD;
         nd_len   = '0;
         nd_chain = '0;
      end else if (v_ff == ROOT_ODD) begin
         nd_link  = ROOT_ODD;
         nd_len   = '1;
         nd_chain = '0;
      end else begin
         nd_link  = node_rd[NODE_W-1:0];
         nd_len   = node_rd[NODE_W +: LEN_W];
         nd_chain = node_rd[NODE_W+LEN_W +: NODE_W];
      end
      if (state_ff == ST_NODE) begin
         cur_len   = nd_len;
         cur_link  = nd_link;
         cur_chain = nd_chain;
      end else begin
         cur_len   = len_v_ff;
         cur_link  = link_v_ff;
         cur_chain = chain_v_ff;
      end
      idx        = {1'b0, 1'b0, pos_ff} - {cur_len[LEN_W-1], cur_len} - (LEN_W+1)'(1);
      idx_ok     = !idx[LEN_W] && (idx != '0);
      child_addr = CHILD_AW'(v_ff) * CHILD_AW'(ALPHABET) + CHILD_AW'(c_ff);
      child_hit  = (child_rd[NODE_W +: EPOCH_W] == epoch_ff) && (child_rd[NODE_W-1:0] != '0);
      child_val  = child_hit ? child_rd[NODE_W-1:0] : '0;
      np         = count_ff + NODE_W'(1);
      chain_f    = nd_chain;
      chain_new  = ((chain_u_ff > chain_f) ? chain_u_ff : chain_f) + NODE_W'(1);
   end

   always_comb begin
      state_in     = state_ff;
      c_in         = c_ff;
      end_in       = end_ff;
      pend_in      = pend_ff;
      epoch_in     = epoch_ff;
      sweep_in     = sweep_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      best_in      = best_ff;
      ovf_in       = ovf_ff;
      v_in         = v_ff;
      walk_in      = walk_ff;
      len_v_in     = len_v_ff;
      link_v_in    = link_v_ff;
      chain_v_in   = chain_v_ff;
      len_u_in     = len_u_ff;
      link_u_in    = link_u_ff;
      chain_u_in   = chain_u_ff;
      cu_addr_in   = cu_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_path_in  = rsp_path_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      req_tready   = 1'b0;
      text_we      = 1'b0;
      text_waddr   = pos_ff + POS_W'(1);
      text_raddr   = idx[POS_W-1:0];
      node_we      = 1'b0;
      node_wd      = {chain_new, len_u_ff + LEN_W'(2), child_val};
      node_raddr   = v_ff;
      child_we     = 1'b0;
      child_waddr  = cu_addr_ff;
      child_wd     = {epoch_ff, np};
      child_raddr  = child_addr;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               c_in   = req_tdata[LETTER_W-1:0];
               end_in = req_tlast;
               state_in = ST_LETTER;
               if (req_tuser) begin
                  count_in = NODE_W'(1);
                  last_in  = '0;
                  pos_in   = '0;
                  best_in  = '0;
                  ovf_in   = 1'b0;
                  epoch_in = epoch_ff + EPOCH_W'(1);
                  if (epoch_in == '0) begin
                     pend_in  = 1'b1;
                     state_in = ST_CLEAR;
                  end
               end
            end
         end
         ST_CLEAR: begin
            child_we    = 1'b1;
            child_waddr = sweep_ff;
            child_wd    = '0;
            sweep_in    = sweep_ff + CHILD_AW'(1);
            if (sweep_ff == SWEEP_LAST) begin
               sweep_in = '0;
               pend_in  = 1'b0;
               state_in = pend_ff ? ST_LETTER : ST_IDLE;
            end
         end
         ST_LETTER: begin
            state_in = ST_FINISH;
            if (int'(c_ff) < ALPHABET) begin
               if (int'(pos_ff) >= MAX_LEN) begin
                  ovf_in = 1'b1;
               end else begin
                  text_we    = 1'b1;
                  pos_in     = pos_ff + POS_W'(1);
                  v_in       = last_ff;
                  node_raddr = last_ff;
                  walk_in    = 1'b0;
                  state_in   = ST_NODE;
               end
            end
         end
         ST_NODE, ST_TEXT: begin
            len_v_in   = cur_len;
            link_v_in  = cur_link;
            chain_v_in = cur_chain;
            if ((v_ff == ROOT_ODD) || (state_ff == ST_TEXT && text_rd == c_ff)) begin
               if (!walk_ff) begin
                  len_u_in   = cur_len;
                  link_u_in  = cur_link;
                  chain_u_in = cur_chain;
                  cu_addr_in = child_addr;
                  state_in   = ST_CHILD;
               end else begin
                  state_in = ST_FCHILD;
               end
            end else if (state_ff == ST_NODE && idx_ok) begin
               state_in = ST_TEXT;
            end else begin
               v_in       = cur_link;
               node_raddr = cur_link;
               state_in   = ST_NODE;
            end
         end
         ST_CHILD: begin
            if (child_hit) begin
               last_in  = child_val;
               state_in = ST_FINISH;
            end else if (int'(count_ff) + 1 < NODES) begin
               walk_in    = 1'b1;
               v_in       = link_u_ff;
               node_raddr = link_u_ff;
               state_in   = ST_NODE;
            end else begin
               last_in  = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FCHILD: begin
            v_in       = child_val;
            node_raddr = child_val;
            link_v_in  = child_val;
            state_in   = ST_FNODE;
         end
         ST_FNODE: begin
            node_wd  = {chain_new, len_u_ff + LEN_W'(2), link_v_ff};
            node_we  = 1'b1;
            child_we = 1'b1;
            count_in = np;
            last_in  = np;
            if (chain_new > best_ff) begin
               best_in = chain_new;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!end_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_path_in  = RESULT_W'(best_ff);
               rsp_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pend_ff      <= 1'b0;
         epoch_ff     <= '0;
         sweep_ff     <= '0;
         count_ff     <= NODE_W'(1);
         last_ff      <= '0;
         pos_ff       <= '0;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         epoch_ff     <= epoch_in;
         sweep_ff     <= sweep_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         pos_ff       <= pos_in;
         best_ff      <= best_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      c_ff       <= c_in;
      end_ff     <= end_in;
      v_ff       <= v_in;
      walk_ff    <= walk_in;
      len_v_ff   <= len_v_in;
      link_v_ff  <= link_v_in;
      chain_v_ff <= chain_v_in;
      len_u_ff   <= len_u_in;
      link_u_ff  <= link_u_in;
      chain_u_ff <= chain_u_in;
      cu_addr_ff <= cu_addr_in;
      rsp_path_ff <= rsp_path_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ovf_ff, rsp_path_ff};

endmodule

### verif/palindromic_tree_longest_chain_unit_test.sv
`timescale 1ns / 100ps

module palindromic_tree_longest_chain_unit_test;
   import ptlc_pkg::*;

   localparam int MAX_LETTERS = MAX_LEN_DEF;
   localparam int LETTERS     = ALPHABET_DEF;
   localparam int NODE_SLOTS  = MAX_LETTERS + 2;
   localparam int STALL_LIMIT = 400000;
   localparam int SETTLE      = 300;

   typedef struct packed {
      logic [RESULT_W-1:0] longest_path;
      logic                overflowed;
   } chain_result_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [4:0] letter, [7:5] zero
   logic        req_tuser;   // starts_string
   logic        req_tlast;   // ends_string
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [12:0] longest_path, [13] overflowed, [15:14] zero

   chain_result_t pending_results[$];
   int            error_count;
   int            hold_requests;
   int            hold_served;
   int            hold_left;
   int            ready_mode;
   int            idle_cycles;
   int            burst_left;

   int text_letters[0:MAX_LETTERS];
   int edge_to[0:NODE_SLOTS-1][0:LETTERS-1];
   int link_of[0:NODE_SLOTS-1];
   int len_of[0:NODE_SLOTS-1];
   int chain_of[0:NODE_SLOTS-1];
   int nodes_used;
   int tail_node;
   int letters_held;
   int best_chain;
   bit overflow_seen;

   palindromic_tree_longest_chain_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void restart_tree();
      nodes_used = 1;
      tail_node = 0;
      letters_held = 0;
      best_chain = 0;
      overflow_seen = 1'b0;
      text_letters[0] = -1;
      len_of[0] = 0;
      link_of[0] = 1;
      chain_of[0] = 0;
      len_of[1] = -1;
      link_of[1] = 1;
      chain_of[1] = 0;
   endfunction

   function automatic bit letter_mirrors(int node, int pos);
      int idx;
      idx = pos - len_of[node] - 1;
      if (idx <= 0 || idx > pos) begin
         return 1'b0;
      end
      return text_letters[idx] == text_letters[pos];
   endfunction

   function automatic int find_extendable(int node, int pos);
      int steps;
      steps = 0;
      while (node != 1 && !letter_mirrors(node, pos) && steps < NODE_SLOTS) begin
         node = link_of[node % NODE_SLOTS];
         steps++;
      end
      if (!letter_mirrors(node, pos)) begin
         node = 1;
      end
      return node;
   endfunction

   function automatic void add_letter(int c);
      int pos;
      int parent;
      int fresh;
      int target;
      int inner;
      if (letters_held >= MAX_LETTERS) begin
         overflow_seen = 1'b1;
         return;
      end
      letters_held++;
      pos = letters_held;
      text_letters[pos] = c;
      parent = find_extendable(tail_node, pos);
      if (edge_to[parent][c] == 0 && nodes_used + 1 < NODE_SLOTS) begin
         nodes_used++;
         fresh = nodes_used;
         len_of[fresh] = len_of[parent] + 2;
         target = edge_to[find_extendable(link_of[parent], pos)][c];
         link_of[fresh] = target;
         inner = (chain_of[parent] > chain_of[target]) ? chain_of[parent] : chain_of[target];
         chain_of[fresh] = inner + 1;
         if (chain_of[fresh] > best_chain) begin
            best_chain = chain_of[fresh];
         end
         edge_to[parent][c] = fresh;
      end
      tail_node = edge_to[parent][c];
   endfunction

   function automatic void predict_chain(logic [4:0] letter, logic starts, logic ends);
      chain_result_t res;
      if (starts) begin
         for (int v = 0; v <= nodes_used && v < NODE_SLOTS; v++) begin
            for (int k = 0; k < LETTERS; k++) begin
               edge_to[v][k] = 0;
            end
         end
         restart_tree();
      end
      if (letter < LETTERS) begin
         add_letter(int'(letter));
      end
      if (ends) begin
         res.longest_path = best_chain[RESULT_W-1:0];
         res.overflowed = overflow_seen;
         pending_results.push_back(res);
      end
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   task automatic send_letter(logic [4:0] letter, logic starts, logic ends);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, letter};
      req_tuser <= starts;
      req_tlast <= ends;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_chain(letter, starts, ends);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic send_word(int letters[], bit ends);
      foreach (letters[i]) begin
         send_letter(letters[i][4:0], i == 0, ends && i == letters.size() - 1);
      end
   endtask

   task automatic test_directed();
      send_letter(5'd1, 1'b0, 1'b0);
      send_letter(5'd1, 1'b0, 1'b1);
      send_letter(5'd0, 1'b1, 1'b1);
      send_letter(5'd25, 1'b1, 1'b1);
      send_word('{0, 0, 0, 0, 0}, 1'b1);
      send_word('{0, 1, 0, 2, 0, 1, 0}, 1'b1);
      send_letter(5'd31, 1'b1, 1'b1);
      send_letter(5'd26, 1'b1, 1'b0);
      send_letter(5'd25, 1'b0, 1'b0);
      send_letter(5'd30, 1'b0, 1'b0);
      send_letter(5'd25, 1'b0, 1'b1);
      send_letter(5'd25, 1'b0, 1'b1);
      send_letter(5'd0, 1'b0, 1'b1);
      wait_for_results();
   endtask

   task automatic test_overflow();
      for (int i = 0; i < MAX_LETTERS + 4; i++) begin
         send_letter(5'($urandom_range(0, 1)), i == 0, i == MAX_LETTERS + 3);
      end
      send_letter(5'd1, 1'b0, 1'b1);
      send_letter(5'd1, 1'b1, 1'b1);
      wait_for_results();
   endtask

   task automatic test_random_strings();
      int sent;
      int word_len;
      int top_letter;
      logic [4:0] letter;
      bit with_start;
      sent = 0;
      while (sent < 1000) begin
         word_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
         case ($urandom_range(0, 3))
            0: top_letter = 1;
            1: top_letter = 2;
            2: top_letter = 4;
            default: top_letter = LETTERS - 1;
         endcase
         with_start = ($urandom_range(0, 7) != 0);
         for (int i = 0; i < word_len; i++) begin
            if ($urandom_range(0, 19) == 0) begin
               letter = 5'($urandom_range(LETTERS, 31));
            end else begin
               letter = 5'($urandom_range(0, top_letter));
            end
            send_letter(letter, with_start && i == 0,
                        (i == word_len - 1) ? ($urandom_range(0, 9) != 0)
                                            : ($urandom_range(0, 29) == 0));
            sent++;
         end
      end
      wait_for_results();
   endtask

   task automatic test_backpressure();
      hold_requests++;
      for (int i = 0; i < 40; i++) begin
         send_letter(5'($urandom_range(0, 2)), i % 4 == 0, 1'b1);
      end
      wait_for_results();
   endtask

   always @(posedge clock) begin
      chain_result_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
         ready_mode <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[12:0], -1);
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[12:0] !== want.longest_path) begin
                  report_mismatch("longest_path", rsp_tdata[12:0], want.longest_path);
               end
               if (rsp_tdata[13] !== want.overflowed) begin
                  report_mismatch("overflowed", rsp_tdata[13], want.overflowed);
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left <= 600;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            if ($urandom_range(0, 63) == 0) begin
               ready_mode <= $urandom_range(0, 3);
            end
            rsp_tready <= (ready_mode == 0) ? 1'b1 : ($urandom_range(0, ready_mode) == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      error_count = 0;
      hold_requests = 0;
      hold_served = 0;
      idle_cycles = 0;
      burst_left = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      for (int v = 0; v < NODE_SLOTS; v++) begin
         for (int k = 0; k < LETTERS; k++) begin
            edge_to[v][k] = 0;
         end
      end
      restart_tree();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_strings();
      test_overflow();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
